[design/krt_pkg.sv]
// Shared types and constants for the keyed record table.
// Used by every module of the block but krt_ram; depends on nothing.
package krt_pkg;

  localparam int KEY_W        = 37;
  localparam int HANDLE_W     = 16;
  localparam int COUNT_OUT_W  = 5;
  localparam int CAPACITY_DEF = 16;

  // Request codes as they arrive on the op field
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [KEY_W-1:0]    person_key;
    logic [HANDLE_W-1:0] record_handle;
  } in_word_t;

  typedef struct packed {
    status_t                status;
    logic [HANDLE_W-1:0]    found_handle;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_word_t;

  // Head of the request queue as seen by the engine
  typedef struct packed {
    logic     valid;
    logic     is_search;
    in_word_t word;
  } q_head_t;

endpackage

[design/krt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/krt_front.sv]
// Request front end: takes words on the start/busy handshake, tags search
// requests and holds them in a two-entry queue. Depends on krt_pkg.
module krt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  krt_pkg::in_word_t in_word,
  output logic              busy,
  input  logic              pop,
  output krt_pkg::q_head_t  head
);

  typedef struct packed {
    logic              is_search;
    krt_pkg::in_word_t word;
  } slot_t;

  slot_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  logic       do_pop;
  slot_t      incoming;

  assign busy   = (fill_r == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (fill_r != 2'd0);

  // Classify: remove and lookup need a table scan
  always_comb begin
    incoming.word      = in_word;
    incoming.is_search = (in_word.op == krt_pkg::OP_REMOVE) ||
                         (in_word.op == krt_pkg::OP_LOOKUP);
  end

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !do_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (!push && do_pop) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= incoming;
    end
  end

  assign head.valid     = (fill_r != 2'd0);
  assign head.is_search = slot_r[rd_ptr_r].is_search;
  assign head.word      = slot_r[rd_ptr_r].word;

endmodule

[design/krt_engine.sv]
// Table engine: runs insert, remove, lookup and clear against the key and
// handle RAMs and registers one result word per request. Depends on krt_pkg.
module krt_engine #(
  parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  krt_pkg::q_head_t   head,
  output logic               pop,
  output logic               out_valid,
  output krt_pkg::out_word_t out_word
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_CMP   = 5'b00100,
    S_SH_RD = 5'b01000,
    S_SH_WR = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [CW-1:0]                idx_inc;
  logic [CW-1:0]                cnt_dec;
  logic [krt_pkg::KEY_W-1:0]    key_r, key_nxt;
  krt_pkg::op_t                 op_r, op_nxt;
  logic [krt_pkg::HANDLE_W-1:0] found_r, found_nxt;

  logic                         we;
  logic [AW-1:0]                waddr;
  logic [AW-1:0]                raddr;
  logic [krt_pkg::KEY_W-1:0]    wkey, rkey;
  logic [krt_pkg::HANDLE_W-1:0] whandle, rhandle;

  logic                         emit;
  krt_pkg::status_t             emit_status;
  logic [krt_pkg::HANDLE_W-1:0] emit_handle;
  logic [CW+4:0]                count_ext;

  logic                         out_valid_r;
  krt_pkg::out_word_t           out_word_r;

  assign idx_inc = idx_r + CW'(1);
  assign cnt_dec = cnt_r - CW'(1);

  // Sequence the table operations
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    key_nxt     = key_r;
    op_nxt      = op_r;
    found_nxt   = found_r;
    pop         = 1'b0;
    we          = 1'b0;
    waddr       = idx_r[AW-1:0];
    wkey        = rkey;
    whandle     = rhandle;
    raddr       = idx_r[AW-1:0];
    emit        = 1'b0;
    emit_status = krt_pkg::STAT_OK;
    emit_handle = '0;
    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.is_search) begin
            if (cnt_r == '0) begin
              emit        = 1'b1;
              emit_status = krt_pkg::STAT_NOT_FOUND;
            end else begin
              key_nxt   = head.word.person_key;
              op_nxt    = head.word.op;
              idx_nxt   = '0;
              state_nxt = S_RD;
            end
          end else if (head.word.op == krt_pkg::OP_INSERT) begin
            emit = 1'b1;
            if (cnt_r == CAP_CW) begin
              emit_status = krt_pkg::STAT_FULL;
            end else begin
              we      = 1'b1;
              waddr   = cnt_r[AW-1:0];
              wkey    = head.word.person_key;
              whandle = head.word.record_handle;
              cnt_nxt = cnt_r + CW'(1);
            end
          end else begin
            emit = 1'b1;
            if (cnt_r == '0) begin
              emit_status = krt_pkg::STAT_EMPTY;
            end else begin
              cnt_nxt = '0;
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rkey == key_r) begin
          if (op_r == krt_pkg::OP_LOOKUP) begin
            emit        = 1'b1;
            emit_handle = rhandle;
            state_nxt   = S_IDLE;
          end else if (idx_inc < cnt_r) begin
            found_nxt = rhandle;
            state_nxt = S_SH_RD;
          end else begin
            // removed entry was the last one: nothing to shift
            cnt_nxt     = cnt_dec;
            emit        = 1'b1;
            emit_handle = rhandle;
            state_nxt   = S_IDLE;
          end
        end else if (idx_inc == cnt_r) begin
          emit        = 1'b1;
          emit_status = krt_pkg::STAT_NOT_FOUND;
          state_nxt   = S_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_RD;
        end
      end
      S_SH_RD: begin
        raddr     = idx_inc[AW-1:0];
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        // move entry down one place to close the gap
        we      = 1'b1;
        idx_nxt = idx_inc;
        if (idx_inc < cnt_dec) begin
          state_nxt = S_SH_RD;
        end else begin
          cnt_nxt     = cnt_dec;
          emit        = 1'b1;
          emit_handle = found_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign count_ext = {5'b00000, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= emit;
    end
  end

  // Hold scan context and the result word
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    key_r   <= key_nxt;
    op_r    <= op_nxt;
    found_r <= found_nxt;
    if (emit) begin
      out_word_r.status       <= emit_status;
      out_word_r.found_handle <= emit_handle;
      out_word_r.entry_count  <= count_ext[4:0];
    end
  end

  krt_ram #(
    .WIDTH (krt_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wkey),
    .raddr (raddr),
    .rdata (rkey)
  );

  krt_ram #(
    .WIDTH (krt_pkg::HANDLE_W),
    .DEPTH (CAPACITY)
  ) u_handle_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (whandle),
    .raddr (raddr),
    .rdata (rhandle)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[design/keyed_record_table.sv]
// Top level of the keyed record table: request queue front end plus engine.
// Depends on krt_pkg, krt_front, krt_engine (which uses krt_ram).
//
//   channel   handshake             word
//   request   start / busy          in_word  (op, person_key, record_handle)
//   result    out_valid strobe      out_word (status, found_handle, entry_count)
//
// Insert, clear and a search of an empty table finish in the idle state;
// lookup reads and compares each entry in turn, and remove also shifts each
// later entry one place down, set by the single read port of the RAMs.
// A result word strobes for one cycle, at the earliest once its request has
// passed the queue slot and the result register; the receiver cannot hold it off.
// Synchronous active-low reset empties the table and the queue; the RAMs are
// not cleared. busy rises while the two-entry request queue is full.
module keyed_record_table #(
  parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  krt_pkg::in_word_t  in_word,
  output logic               out_valid,
  output krt_pkg::out_word_t out_word
);

  krt_pkg::q_head_t head;
  logic             pop;

  krt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_word (in_word),
    .busy    (busy),
    .pop     (pop),
    .head    (head)
  );

  krt_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  localparam logic [krt_pkg::COUNT_OUT_W-1:0] CAP_LOW = krt_pkg::COUNT_OUT_W'(CAPACITY);

  // A full table reports exactly its capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == krt_pkg::STAT_FULL |-> out_word.entry_count == CAP_LOW)
    else $error("full status with wrong entry count");

  // An already empty table reports a zero count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == krt_pkg::STAT_EMPTY |-> out_word.entry_count == '0)
    else $error("empty status with nonzero entry count");

  // A failed search returns no handle
  a_miss_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == krt_pkg::STAT_NOT_FOUND |-> out_word.found_handle == '0)
    else $error("not-found status with a handle");

  // Backpressure only when the queue holds work
  a_busy_queue: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> head.valid)
    else $error("busy with an empty request queue");
`endif

endmodule
